[sv/cgco_pkg.sv]
package cgco_pkg;

  localparam int unsigned AXES   = 2;
  localparam int unsigned SLOTS  = 5;
  localparam int unsigned PROBES = 8;
  localparam int unsigned CELLS  = PROBES + 1;

  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;

  // position slots per axis: centre, +radius, -radius, +diag, -diag
  localparam int unsigned SL_CTR  = 0;
  localparam int unsigned SL_PR   = 1;
  localparam int unsigned SL_NR   = 2;
  localparam int unsigned SL_PD   = 3;
  localparam int unsigned SL_ND   = 4;

  // probe order: +x, -x, +y, -y, (+d,+d), (-d,+d), (+d,-d), (-d,-d)
  localparam int unsigned PROBE_XS [PROBES] = '{SL_PR, SL_NR, SL_CTR, SL_CTR,
                                               SL_PD, SL_ND, SL_PD, SL_ND};
  localparam int unsigned PROBE_YS [PROBES] = '{SL_CTR, SL_CTR, SL_PR, SL_NR,
                                               SL_PD, SL_PD, SL_ND, SL_ND};

  localparam int unsigned DW = 34;  // signed offset from origin
  localparam int unsigned QW = 33;  // magnitude and cell quotient
  localparam int unsigned PW = QW + 32;

  localparam logic [15:0] DIAG_Q16 = 16'd46341;

  localparam logic [1:0] CFG_GRID_ORIGIN   = 2'd0;
  localparam logic [1:0] CFG_CELL_SCALE    = 2'd1;
  localparam logic [1:0] CFG_CIRCLE_RADIUS = 2'd2;
  localparam logic [1:0] CFG_GRID_SIZE     = 2'd3;

  localparam logic [31:0] SCALE_RST     = 32'd65536;
  localparam logic [8:0]  GRID_SIZE_RST = 9'd16;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [15:0] cell_number;
    logic        is_main_cell;
    logic [3:0]  overlap_count;
    logic        last_cell;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] origin;
    logic [31:0]        scale;
    logic [30:0]        radius;
    logic [30:0]        diag;
  } cfg_t;

endpackage

[sv/cgco_stream_if.sv]
interface cgco_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/cgco_cfg.sv]
module cgco_cfg #(
  parameter int unsigned MAX_GRID = 256,
  localparam int unsigned NW = $clog2(MAX_GRID + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [1:0]          idx_i,
  input  logic [31:0]         wdata_i,
  output cgco_pkg::cfg_t      cfg_o,
  output logic [NW-1:0]       size_o
);

  cgco_pkg::cfg_t cfg_q;
  logic [8:0]     grid_size_q;
  logic [46:0]    diag_prod;

  assign diag_prod = 47'(wdata_i[30:0]) * 47'(cgco_pkg::DIAG_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin <= '0;
      cfg_q.scale  <= cgco_pkg::SCALE_RST;
      cfg_q.radius <= '0;
      cfg_q.diag   <= '0;
      grid_size_q  <= cgco_pkg::GRID_SIZE_RST;
    end else if (we_i) begin
      unique case (idx_i)
        cgco_pkg::CFG_GRID_ORIGIN:   cfg_q.origin <= wdata_i;
        cgco_pkg::CFG_CELL_SCALE:    cfg_q.scale  <= wdata_i;
        cgco_pkg::CFG_CIRCLE_RADIUS: begin
          cfg_q.radius <= wdata_i[30:0];
          cfg_q.diag   <= diag_prod[46:16];
        end
        cgco_pkg::CFG_GRID_SIZE:     grid_size_q  <= wdata_i[8:0];
      endcase
    end
  end

  always_comb begin
    if (grid_size_q == '0) begin
      size_o = NW'(1);
    end else if (32'(grid_size_q) > 32'(MAX_GRID)) begin
      size_o = NW'(MAX_GRID);
    end else begin
      size_o = NW'(grid_size_q);
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/cgco_map.sv]
module cgco_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cgco_pkg::in_item_t   in_data_i,
  input  cgco_pkg::cfg_t       cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [cgco_pkg::AXES-1:0][cgco_pkg::SLOTS-1:0]                   out_neg_o,
  output logic [cgco_pkg::AXES-1:0][cgco_pkg::SLOTS-1:0][cgco_pkg::QW-1:0] out_q_o
);

  localparam int unsigned AXES  = cgco_pkg::AXES;
  localparam int unsigned SLOTS = cgco_pkg::SLOTS;
  localparam int unsigned DW    = cgco_pkg::DW;
  localparam int unsigned QW    = cgco_pkg::QW;
  localparam int unsigned PW    = cgco_pkg::PW;

  logic               a_valid_q, b_valid_q, c_valid_q;
  logic               a_ready, b_ready, c_ready;
  cgco_pkg::in_item_t a_data_q;

  logic [AXES-1:0][SLOTS-1:0]         b_neg_d, b_neg_q;
  logic [AXES-1:0][SLOTS-1:0][QW-1:0] b_mag_d, b_mag_q;
  logic [AXES-1:0][SLOTS-1:0]         c_neg_q;
  logic [AXES-1:0][SLOTS-1:0][QW-1:0] c_q_d, c_q_q;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // offset from origin and magnitude
  always_comb begin
    logic [31:0]   ctr;
    logic [DW-1:0] base;
    logic [DW-1:0] rad;
    logic [DW-1:0] dia;
    logic [DW-1:0] d [SLOTS];
    rad = DW'(cfg_i.radius);
    dia = DW'(cfg_i.diag);
    for (int a = 0; a < AXES; a++) begin
      ctr  = (a == cgco_pkg::AX_Y) ? a_data_q.centre_y : a_data_q.centre_x;
      base = {{(DW-32){ctr[31]}}, ctr} - {{(DW-32){cfg_i.origin[31]}}, cfg_i.origin};
      d[cgco_pkg::SL_CTR] = base;
      d[cgco_pkg::SL_PR]  = base + rad;
      d[cgco_pkg::SL_NR]  = base - rad;
      d[cgco_pkg::SL_PD]  = base + dia;
      d[cgco_pkg::SL_ND]  = base - dia;
      for (int s = 0; s < SLOTS; s++) begin
        b_neg_d[a][s] = d[s][DW-1];
        b_mag_d[a][s] = d[s][DW-1] ? QW'(-d[s]) : QW'(d[s]);
      end
    end
  end

  // magnitude times scale, integer part of the Q32.32 product
  always_comb begin
    logic [PW-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      for (int s = 0; s < SLOTS; s++) begin
        prod        = PW'(b_mag_q[a][s]) * PW'(cfg_i.scale);
        c_q_d[a][s] = prod[PW-1:32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_data_q <= in_data_i;
    end
    if (b_ready && a_valid_q) begin
      b_neg_q <= b_neg_d;
      b_mag_q <= b_mag_d;
    end
    if (c_ready && b_valid_q) begin
      c_neg_q <= b_neg_q;
      c_q_q   <= c_q_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_neg_o   = c_neg_q;
  assign out_q_o     = c_q_q;

endmodule

[sv/cgco_emit.sv]
module cgco_emit #(
  parameter int unsigned MAX_GRID = 256,
  localparam int unsigned NW = $clog2(MAX_GRID + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [cgco_pkg::AXES-1:0][cgco_pkg::SLOTS-1:0]                   in_neg_i,
  input  logic [cgco_pkg::AXES-1:0][cgco_pkg::SLOTS-1:0][cgco_pkg::QW-1:0] in_q_i,
  input  logic [NW-1:0]        size_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cgco_pkg::out_item_t  out_data_o
);

  localparam int unsigned AXES   = cgco_pkg::AXES;
  localparam int unsigned SLOTS  = cgco_pkg::SLOTS;
  localparam int unsigned PROBES = cgco_pkg::PROBES;
  localparam int unsigned CELLS  = cgco_pkg::CELLS;
  localparam int unsigned QW     = cgco_pkg::QW;
  localparam int unsigned CW     = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int unsigned NUMW   = CW + NW + 1;

  logic [AXES-1:0][SLOTS-1:0]         inr;
  logic [AXES-1:0][SLOTS-1:0][CW-1:0] coord;
  logic [AXES-1:0][CW-1:0]            main_c;
  logic [CELLS-1:0][CW-1:0]           cand_col, cand_row;
  logic [CELLS-1:0]                   cand_ok, keep;

  logic                     h_valid_q;
  logic [CELLS-1:0]         h_mask_q;
  logic [3:0]               h_count_q;
  logic [CELLS-1:0][CW-1:0] h_col_q, h_row_q;

  logic [CELLS-1:0] sel, rest;
  logic [CW-1:0]    col_s, row_s;
  logic [NUMW-1:0]  num_s;
  logic             out_load, h_done, take;

  logic                o_valid_q;
  cgco_pkg::out_item_t o_data_q;

  // cell coordinates, range check and clamp
  always_comb begin
    logic zero, below;
    for (int a = 0; a < AXES; a++) begin
      for (int s = 0; s < SLOTS; s++) begin
        zero        = (in_q_i[a][s] == '0);
        below       = (in_q_i[a][s] < QW'(size_i));
        inr[a][s]   = zero || (!in_neg_i[a][s] && below);
        coord[a][s] = in_q_i[a][s][CW-1:0];
        if (s == cgco_pkg::SL_CTR) begin
          if (in_neg_i[a][s] || zero) begin
            main_c[a] = '0;
          end else if (below) begin
            main_c[a] = in_q_i[a][s][CW-1:0];
          end else begin
            main_c[a] = CW'(size_i - NW'(1));
          end
        end
      end
    end
  end

  // candidate list and duplicate removal
  always_comb begin
    cand_col[0] = main_c[cgco_pkg::AX_X];
    cand_row[0] = main_c[cgco_pkg::AX_Y];
    cand_ok[0]  = 1'b1;
    for (int p = 0; p < PROBES; p++) begin
      cand_col[p+1] = coord[cgco_pkg::AX_X][cgco_pkg::PROBE_XS[p]];
      cand_row[p+1] = coord[cgco_pkg::AX_Y][cgco_pkg::PROBE_YS[p]];
      cand_ok[p+1]  = inr[cgco_pkg::AX_X][cgco_pkg::PROBE_XS[p]] &&
                      inr[cgco_pkg::AX_Y][cgco_pkg::PROBE_YS[p]];
    end
    for (int k = 0; k < CELLS; k++) begin
      keep[k] = cand_ok[k];
      for (int j = 0; j < k; j++) begin
        if (cand_ok[j] && cand_col[j] == cand_col[k] && cand_row[j] == cand_row[k]) begin
          keep[k] = 1'b0;
        end
      end
    end
  end

  // next cell to send: lowest pending slot
  always_comb begin
    logic found;
    sel   = '0;
    found = 1'b0;
    for (int k = 0; k < CELLS; k++) begin
      if (h_mask_q[k] && !found) begin
        sel[k] = 1'b1;
        found  = 1'b1;
      end
    end
    col_s = '0;
    row_s = '0;
    for (int k = 0; k < CELLS; k++) begin
      col_s = col_s | (h_col_q[k] & {CW{sel[k]}});
      row_s = row_s | (h_row_q[k] & {CW{sel[k]}});
    end
    rest  = h_mask_q & ~sel;
    num_s = NUMW'(row_s) * NUMW'(size_i) + NUMW'(col_s);
  end

  assign out_load   = h_valid_q && (!o_valid_q || out_ready_i);
  assign h_done     = out_load && (rest == '0);
  assign in_ready_o = !h_valid_q || h_done;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (take) begin
        h_valid_q <= 1'b1;
      end else if (h_done) begin
        h_valid_q <= 1'b0;
      end
      if (out_load) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      h_mask_q  <= keep;
      h_count_q <= 4'($countones(keep));
      h_col_q   <= cand_col;
      h_row_q   <= cand_row;
    end else if (out_load) begin
      h_mask_q  <= rest;
    end
    if (out_load) begin
      o_data_q.cell_col      <= 8'(col_s);
      o_data_q.cell_row      <= 8'(row_s);
      o_data_q.cell_number   <= 16'(num_s);
      o_data_q.is_main_cell  <= sel[0];
      o_data_q.overlap_count <= h_count_q;
      o_data_q.last_cell     <= (rest == '0);
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

[sv/circle_grid_cell_overlap_top.sv]
// circle to grid cell overlap
// item_i carries one circle centre (centre_x, centre_y, signed Q16.16) per
// transaction; cell_o returns one transaction per distinct grid cell the
// circle touches: the main cell first, then the in-grid, non-repeated
// probe cells in +x, -x, +y, -y and diagonal order. each result carries the
// total count, and last_cell marks the final one of a circle.
// configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
// (grid_origin, cell_scale, circle_radius, grid_size); write only while idle.
// the first cell of a circle passes the input, offset, scale product, cell
// list and output registers in that order before it is valid on cell_o.
// throughput: cells leave at one per cycle from the cell list register while
// cell_o does not stall, and a circle has 1 to 9 cells; the cell list loads
// the next circle in the same cycle as the last cell of a circle leaves.
// when cell_o stalls, the output holds, the cell list and the three stages
// ahead of it fill, and item_i.ready then drops until cells are taken.
// reset clears all pipeline valid flags and loads the register defaults.
module circle_grid_cell_overlap_top #(
  parameter int unsigned MAX_GRID = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cgco_stream_if.sink   item_i,
  cgco_stream_if.source cell_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned NW = $clog2(MAX_GRID + 1);

  cgco_pkg::cfg_t    cfg;
  logic [NW-1:0]     size_eff;
  logic              map_valid, map_ready;
  logic [cgco_pkg::AXES-1:0][cgco_pkg::SLOTS-1:0]                   map_neg;
  logic [cgco_pkg::AXES-1:0][cgco_pkg::SLOTS-1:0][cgco_pkg::QW-1:0] map_q;

  cgco_cfg #(
    .MAX_GRID (MAX_GRID)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg),
    .size_o  (size_eff)
  );

  cgco_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_data_i   (item_i.data),
    .cfg_i       (cfg),
    .out_valid_o (map_valid),
    .out_ready_i (map_ready),
    .out_neg_o   (map_neg),
    .out_q_o     (map_q)
  );

  cgco_emit #(
    .MAX_GRID (MAX_GRID)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (map_valid),
    .in_ready_o  (map_ready),
    .in_neg_i    (map_neg),
    .in_q_i      (map_q),
    .size_i      (size_eff),
    .out_valid_o (cell_o.valid),
    .out_ready_i (cell_o.ready),
    .out_data_o  (cell_o.data)
  );

endmodule

[sv/cgco_checker.sv]
module cgco_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input cgco_pkg::out_item_t out_data_i
);

  logic       first_q;
  logic [3:0] count_q;
  logic       out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      count_q <= '0;
    end else if (out_acc) begin
      first_q <= out_data_i.last_cell;
      count_q <= out_data_i.overlap_count;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output changed while stalled");

  a_main_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> out_data_i.is_main_cell == first_q)
    else $error("main cell not at start of circle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.overlap_count != '0 &&
                    out_data_i.overlap_count <= 4'(cgco_pkg::CELLS))
    else $error("overlap count out of range");

  a_single_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_main_cell |->
      out_data_i.last_cell == (out_data_i.overlap_count == 4'd1))
    else $error("last flag disagrees with count on main cell");

  a_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_i.is_main_cell |-> out_data_i.overlap_count == count_q)
    else $error("overlap count changed within a circle");

endmodule

bind circle_grid_cell_overlap_top cgco_checker u_cgco_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (cell_o.valid),
  .out_ready_i (cell_o.ready),
  .out_data_i  (cell_o.data)
);
